@@ rtl/core/sahc_pkg.sv @@
// Shared types, sizes and constants of the sensor averaging controller.
// No dependencies; every other file refers to it, the design files by scope and the testbench by import.
`timescale 1ns / 1ps

package sahc_pkg;

	// Sample and accumulator sizes.
	localparam int ADC_W     = 10;
	localparam int AVG_COUNT = 5;
	localparam int CNT_W     = $clog2(AVG_COUNT + 1);
	localparam int SUM_W     = ADC_W + $clog2(AVG_COUNT);

	// Average by reciprocal: avg = (sum * RECIP_MULT) >> RECIP_SHIFT, exact for every sum.
	localparam int RECIP_SHIFT = SUM_W + $clog2(AVG_COUNT) + 1;
	localparam int RECIP_MULT  = ((1 << RECIP_SHIFT) + AVG_COUNT - 1) / AVG_COUNT;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int PROD_W      = SUM_W + RECIP_W;

	// Thresholds are compared in 1/1024 units.
	localparam int RATIO_W     = 12;
	localparam int SCALE_SHIFT = 10;
	localparam int THR_W       = ADC_W + RATIO_W;

	// Percent mapping.
	localparam int PCT_W          = 7;
	localparam int PCT_SCALE      = 100;
	localparam int ZERO_PCT_LIMIT = 20;
	localparam int FULL_PCT_LIMIT = 80;
	localparam int PCT_FULL_VALUE = 100;
	localparam int NUM_W          = ADC_W + PCT_W;
	localparam int QBIT_W         = $clog2(PCT_W);

	// Queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LIGHT_ZERO_POINT = 3'd0,
		CFG_LIGHT_SPAN       = 3'd1,
		CFG_LIGHT_ON_RATIO   = 3'd2,
		CFG_LIGHT_OFF_RATIO  = 3'd3,
		CFG_TEMP_ON_RATIO    = 3'd4,
		CFG_TEMP_OFF_RATIO   = 3'd5,
		CFG_TOUCH_LOW_RATIO  = 3'd6,
		CFG_TOUCH_HIGH_RATIO = 3'd7
	} cfg_index_t;

	localparam logic [ADC_W-1:0]   RST_LIGHT_ZERO_POINT = 10'd700;
	localparam logic [ADC_W-1:0]   RST_LIGHT_SPAN       = 10'd300;
	localparam logic [RATIO_W-1:0] RST_LIGHT_ON_RATIO   = 12'd1536;
	localparam logic [RATIO_W-1:0] RST_LIGHT_OFF_RATIO  = 12'd1126;
	localparam logic [RATIO_W-1:0] RST_TEMP_ON_RATIO    = 12'd1065;
	localparam logic [RATIO_W-1:0] RST_TEMP_OFF_RATIO   = 12'd1034;
	localparam logic [RATIO_W-1:0] RST_TOUCH_LOW_RATIO  = 12'd512;
	localparam logic [RATIO_W-1:0] RST_TOUCH_HIGH_RATIO = 12'd922;

	typedef struct packed {
		logic [ADC_W-1:0] light_sample;
		logic [ADC_W-1:0] touch_sample;
		logic [ADC_W-1:0] temp_sample;
	} in_item_t;

	typedef struct packed {
		logic [PCT_W-1:0] dim_percent;
		logic             dark_led;
		logic             temp_led;
		logic             motor_reverse;
	} out_item_t;

	// One finished window of averages; is_base marks the first one after reset.
	typedef struct packed {
		logic             is_base;
		logic [ADC_W-1:0] light;
		logic [ADC_W-1:0] touch;
		logic [ADC_W-1:0] temp;
	} avg_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	function automatic logic [ADC_W-1:0] avg_of(input logic [SUM_W-1:0] sum);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(sum) * PROD_W'(RECIP_MULT);
		return prod[RECIP_SHIFT +: ADC_W];
	endfunction

endpackage

@@ rtl/core/sensor_average_hysteresis_controller.sv @@
// Top level of the sensor averaging controller with hysteresis comparators.
// Depends on sahc_pkg, sahc_front, sahc_queue and sahc_back.
`timescale 1ns / 1ps

// Usage:
// Each beat on the sample channel (sample_valid, sample_stall, sample) carries one set of
// light, touch and temperature conversions. Every fifth beat closes a window whose
// truncated averages are formed in the front part and queued for the back part.
// The first window after reset only stores the baseline and gives no result; every
// later window gives exactly one beat on the result channel (result_valid,
// result_stall, result) with the dimming percent, both LED states and the motor
// direction. Configuration registers are written on the cfg channel, which is always
// ready; write them only while the block is idle.
// Throughput: the front takes one sample beat per cycle unless a finished window waits on
// a full queue. The back takes each window through three comparator steps on two shared
// multipliers and, unless the percent saturates, the restoring divider for the percent;
// the divider loop bounds the sustained rate. A closing beat's sums are registered in the
// front and its averages queued; the back then runs its states and loads the result
// register. A stalled result register holds the back part; the two-entry queue then fills
// and the front stalls samples only when a finished window cannot be queued.
// Reset (arst_n low) clears sums, baseline, LED and direction state and loads the
// register defaults; no clearing pass is needed.
module sensor_average_hysteresis_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sample_valid,
	output logic                            sample_stall,
	input  sahc_pkg::in_item_t              sample,
	output logic                            result_valid,
	input  logic                            result_stall,
	output sahc_pkg::out_item_t             result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  sahc_pkg::cfg_index_t            cfg_index,
	input  logic [sahc_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic                    push, pop;
	sahc_pkg::avg_entry_t    push_data, head;
	sahc_pkg::queue_status_t qstat;

	// Front: accumulates sample beats and forms the window averages.
	sahc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.push         (push),
		.push_data    (push_data),
		.qstat        (qstat)
	);

	// Queue: lets the front keep accepting while the back is busy or stalled.
	sahc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	// Back: baseline, comparators, touch toggle, percent divider and result register.
	sahc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

@@ rtl/core/sahc_front.sv @@
// Front part: accepts sample beats, accumulates window sums and forms the averages.
// Depends on sahc_pkg; feeds sahc_queue.
`timescale 1ns / 1ps

module sahc_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    sample_valid,
	output logic                    sample_stall,
	input  sahc_pkg::in_item_t      sample,
	output logic                    push,
	output sahc_pkg::avg_entry_t    push_data,
	input  sahc_pkg::queue_status_t qstat
);

	logic [sahc_pkg::SUM_W-1:0] light_sum_q, touch_sum_q, temp_sum_q;
	logic [sahc_pkg::CNT_W-1:0] count_q;
	logic                       base_valid_q;

	logic [sahc_pkg::SUM_W-1:0] light_sum_s1, touch_sum_s1, temp_sum_s1;
	logic                       valid_s1;
	logic                       base_s1;

	logic [sahc_pkg::SUM_W-1:0] light_next, touch_next, temp_next;
	logic                       accept;
	logic                       last;

	assign sample_stall = valid_s1 && qstat.full;
	assign accept       = sample_valid && !sample_stall;
	assign last         = (count_q == sahc_pkg::CNT_W'(sahc_pkg::AVG_COUNT - 1));
	assign push         = valid_s1 && !qstat.full;

	assign light_next = light_sum_q + sahc_pkg::SUM_W'(sample.light_sample);
	assign touch_next = touch_sum_q + sahc_pkg::SUM_W'(sample.touch_sample);
	assign temp_next  = temp_sum_q + sahc_pkg::SUM_W'(sample.temp_sample);

	always_comb begin
		push_data.is_base = base_s1;
		push_data.light   = sahc_pkg::avg_of(light_sum_s1);
		push_data.touch   = sahc_pkg::avg_of(touch_sum_s1);
		push_data.temp    = sahc_pkg::avg_of(temp_sum_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_sum_q  <= '0;
			touch_sum_q  <= '0;
			temp_sum_q   <= '0;
			count_q      <= '0;
			base_valid_q <= 1'b0;
			valid_s1     <= 1'b0;
		end else begin
			if (push) begin
				valid_s1 <= 1'b0;
			end
			if (accept) begin
				if (last) begin
					valid_s1     <= 1'b1;
					base_valid_q <= 1'b1;
					light_sum_q  <= '0;
					touch_sum_q  <= '0;
					temp_sum_q   <= '0;
					count_q      <= '0;
				end else begin
					light_sum_q <= light_next;
					touch_sum_q <= touch_next;
					temp_sum_q  <= temp_next;
					count_q     <= count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last) begin
			light_sum_s1 <= light_next;
			touch_sum_s1 <= touch_next;
			temp_sum_s1  <= temp_next;
			base_s1      <= !base_valid_q;
		end
	end

endmodule

@@ rtl/core/sahc_queue.sv @@
// Short queue of window averages between the front and the back part.
// Depends on sahc_pkg.
`timescale 1ns / 1ps

module sahc_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  sahc_pkg::avg_entry_t    push_data,
	input  logic                    pop,
	output sahc_pkg::avg_entry_t    head,
	output sahc_pkg::queue_status_t qstat
);

	sahc_pkg::avg_entry_t        entries_q [sahc_pkg::QUEUE_DEPTH];
	logic [sahc_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [sahc_pkg::QCNT_W-1:0] count_q;

	localparam logic [sahc_pkg::QPTR_W-1:0] LAST_PTR =
		sahc_pkg::QPTR_W'(sahc_pkg::QUEUE_DEPTH - 1);

	assign qstat.full  = (count_q == sahc_pkg::QCNT_W'(sahc_pkg::QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head        = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ rtl/core/sahc_back.sv @@
// Back part: baseline store, hysteresis comparators, touch edge toggle and percent divider.
// Depends on sahc_pkg; takes entries from sahc_queue and drives the result register.
`timescale 1ns / 1ps

module sahc_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  sahc_pkg::cfg_index_t            cfg_index,
	input  logic [sahc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  sahc_pkg::avg_entry_t            head,
	input  sahc_pkg::queue_status_t         qstat,
	output logic                            pop,
	output logic                            result_valid,
	input  logic                            result_stall,
	output sahc_pkg::out_item_t             result
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LIGHT,
		S_TEMP,
		S_TOUCH,
		S_DIV,
		S_DONE
	} state_t;

	state_t state_q;

	logic [sahc_pkg::ADC_W-1:0]   light_zero_q, light_span_q;
	logic [sahc_pkg::RATIO_W-1:0] light_on_q, light_off_q;
	logic [sahc_pkg::RATIO_W-1:0] temp_on_q, temp_off_q;
	logic [sahc_pkg::RATIO_W-1:0] touch_low_q, touch_high_q;

	logic [sahc_pkg::ADC_W-1:0] light_base_q, touch_base_q, temp_base_q;
	logic                       dark_q, temp_led_q, dir_q, was_touching_q;

	sahc_pkg::avg_entry_t        cur_q;
	logic [sahc_pkg::NUM_W-1:0]  num_q, lo_q, hi_q, rem_q;
	logic [sahc_pkg::PCT_W-1:0]  pct_q;
	logic [sahc_pkg::QBIT_W-1:0] bit_q;
	sahc_pkg::out_item_t         result_q;
	logic                        result_valid_q;

	logic [sahc_pkg::ADC_W-1:0]   cmp_base, cmp_x;
	logic [sahc_pkg::RATIO_W-1:0] ratio_a, ratio_b;
	logic [sahc_pkg::THR_W-1:0]   prod_a, prod_b, x_scaled;
	logic [sahc_pkg::ADC_W-1:0]   span_eff, light_diff;
	logic [sahc_pkg::NUM_W-1:0]   trial;
	logic                         light_above_zero, in_window;

	assign cfg_ready    = 1'b1;
	assign pop          = (state_q == S_IDLE) && !qstat.empty;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Two multipliers are shared by the light, temperature and touch steps.
	always_comb begin
		case (state_q)
			S_TEMP: begin
				cmp_base = temp_base_q;
				cmp_x    = cur_q.temp;
				ratio_a  = temp_on_q;
				ratio_b  = temp_off_q;
			end
			S_TOUCH: begin
				cmp_base = touch_base_q;
				cmp_x    = cur_q.touch;
				ratio_a  = touch_high_q;
				ratio_b  = touch_low_q;
			end
			default: begin
				cmp_base = light_base_q;
				cmp_x    = cur_q.light;
				ratio_a  = light_on_q;
				ratio_b  = light_off_q;
			end
		endcase
	end

	assign prod_a   = sahc_pkg::THR_W'(cmp_base) * sahc_pkg::THR_W'(ratio_a);
	assign prod_b   = sahc_pkg::THR_W'(cmp_base) * sahc_pkg::THR_W'(ratio_b);
	assign x_scaled = sahc_pkg::THR_W'(cmp_x) << sahc_pkg::SCALE_SHIFT;

	assign in_window = (x_scaled < prod_a) && (x_scaled > prod_b);

	// A zero span divides as a span of one.
	assign span_eff         = (light_span_q == '0) ? sahc_pkg::ADC_W'(1) : light_span_q;
	assign light_above_zero = (cur_q.light > light_zero_q);
	assign light_diff       = cur_q.light - light_zero_q;
	assign trial            = sahc_pkg::NUM_W'(span_eff) << bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_zero_q <= sahc_pkg::RST_LIGHT_ZERO_POINT;
			light_span_q <= sahc_pkg::RST_LIGHT_SPAN;
			light_on_q   <= sahc_pkg::RST_LIGHT_ON_RATIO;
			light_off_q  <= sahc_pkg::RST_LIGHT_OFF_RATIO;
			temp_on_q    <= sahc_pkg::RST_TEMP_ON_RATIO;
			temp_off_q   <= sahc_pkg::RST_TEMP_OFF_RATIO;
			touch_low_q  <= sahc_pkg::RST_TOUCH_LOW_RATIO;
			touch_high_q <= sahc_pkg::RST_TOUCH_HIGH_RATIO;
		end else if (cfg_valid) begin
			case (cfg_index)
				sahc_pkg::CFG_LIGHT_ZERO_POINT: light_zero_q <= cfg_data[sahc_pkg::ADC_W-1:0];
				sahc_pkg::CFG_LIGHT_SPAN:       light_span_q <= cfg_data[sahc_pkg::ADC_W-1:0];
				sahc_pkg::CFG_LIGHT_ON_RATIO:   light_on_q   <= cfg_data;
				sahc_pkg::CFG_LIGHT_OFF_RATIO:  light_off_q  <= cfg_data;
				sahc_pkg::CFG_TEMP_ON_RATIO:    temp_on_q    <= cfg_data;
				sahc_pkg::CFG_TEMP_OFF_RATIO:   temp_off_q   <= cfg_data;
				sahc_pkg::CFG_TOUCH_LOW_RATIO:  touch_low_q  <= cfg_data;
				sahc_pkg::CFG_TOUCH_HIGH_RATIO: touch_high_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			light_base_q   <= '0;
			touch_base_q   <= '0;
			temp_base_q    <= '0;
			dark_q         <= 1'b0;
			temp_led_q     <= 1'b0;
			dir_q          <= 1'b0;
			was_touching_q <= 1'b0;
			bit_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!qstat.empty) begin
						if (head.is_base) begin
							light_base_q <= head.light;
							touch_base_q <= head.touch;
							temp_base_q  <= head.temp;
						end else begin
							cur_q   <= head;
							state_q <= S_LIGHT;
						end
					end
				end
				S_LIGHT: begin
					// The off test wins when both thresholds are met.
					if (x_scaled <= prod_b) begin
						dark_q <= 1'b0;
					end else if (x_scaled >= prod_a) begin
						dark_q <= 1'b1;
					end
					num_q <= light_above_zero ?
						sahc_pkg::NUM_W'(light_diff) * sahc_pkg::NUM_W'(sahc_pkg::PCT_SCALE) :
						'0;
					lo_q <= sahc_pkg::NUM_W'(span_eff) *
						sahc_pkg::NUM_W'(sahc_pkg::ZERO_PCT_LIMIT + 1);
					hi_q <= sahc_pkg::NUM_W'(span_eff) *
						sahc_pkg::NUM_W'(sahc_pkg::FULL_PCT_LIMIT);
					state_q <= S_TEMP;
				end
				S_TEMP: begin
					if (x_scaled > prod_a) begin
						temp_led_q <= 1'b1;
					end else if (x_scaled < prod_b) begin
						temp_led_q <= 1'b0;
					end
					state_q <= S_TOUCH;
				end
				S_TOUCH: begin
					if (in_window && !was_touching_q) begin
						dir_q <= !dir_q;
					end
					was_touching_q <= in_window;
					if (num_q < lo_q) begin
						pct_q   <= '0;
						state_q <= S_DONE;
					end else if (num_q >= hi_q) begin
						pct_q   <= sahc_pkg::PCT_W'(sahc_pkg::PCT_FULL_VALUE);
						state_q <= S_DONE;
					end else begin
						rem_q   <= num_q;
						pct_q   <= '0;
						bit_q   <= sahc_pkg::QBIT_W'(sahc_pkg::PCT_W - 1);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					// Restoring division, one quotient bit per cycle, MSB first.
					if (rem_q >= trial) begin
						rem_q        <= rem_q - trial;
						pct_q[bit_q] <= 1'b1;
					end
					if (bit_q == '0) begin
						state_q <= S_DONE;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
				S_DONE: begin
					if (!result_valid_q || !result_stall) begin
						result_q.dim_percent   <= pct_q;
						result_q.dark_led      <= dark_q;
						result_q.temp_led      <= temp_led_q;
						result_q.motor_reverse <= dir_q;
						result_valid_q         <= 1'b1;
						state_q                <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_dim_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (result_q.dim_percent == '0 ||
			result_q.dim_percent == sahc_pkg::PCT_W'(sahc_pkg::PCT_FULL_VALUE) ||
			(result_q.dim_percent >= sahc_pkg::PCT_W'(sahc_pkg::ZERO_PCT_LIMIT + 1) &&
			 result_q.dim_percent <  sahc_pkg::PCT_W'(sahc_pkg::FULL_PCT_LIMIT))))
		else $error("dim percent outside its mapped ranges");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |->
			(rem_q < (sahc_pkg::NUM_W'(span_eff) << (4'(bit_q) + 4'd1))))
		else $error("divider remainder too large for remaining quotient bits");

	a_base_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !qstat.empty && head.is_base) |=> (state_q == S_IDLE))
		else $error("baseline window started an evaluation");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !result_valid_q) |=> (result_valid_q && state_q == S_IDLE))
		else $error("finished evaluation not loaded into the result register");

endmodule

@@ tb/tb_sensor_average_hysteresis_controller.sv @@
// Self-checking testbench of the sensor averaging controller with hysteresis comparators.
// Depends on sahc_pkg and the sensor_average_hysteresis_controller top level; nothing else.
`timescale 1ns / 1ps

module tb_sensor_average_hysteresis_controller;

	import sahc_pkg::*;

	// Cycles of silence after the last expected result before registers may change.
	// A baseline window makes no result but still passes through the back part.
	localparam int DRAIN_CYCLES = 40;
	// Cycles without any accepted beat on any channel before the run is declared hung.
	localparam int HANG_LIMIT   = 2000;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  sample_valid = 1'b0;
	logic                  sample_stall;
	in_item_t              sample       = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	out_item_t             result;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	cfg_index_t            cfg_index    = CFG_LIGHT_ZERO_POINT;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	sensor_average_hysteresis_controller dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 8 ns period, low phase first.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow copy of the register file, loaded with the reset defaults.
	logic [ADC_W-1:0]   zero_point     = RST_LIGHT_ZERO_POINT;
	logic [ADC_W-1:0]   span           = RST_LIGHT_SPAN;
	logic [RATIO_W-1:0] dark_on_ratio  = RST_LIGHT_ON_RATIO;
	logic [RATIO_W-1:0] dark_off_ratio = RST_LIGHT_OFF_RATIO;
	logic [RATIO_W-1:0] hot_on_ratio   = RST_TEMP_ON_RATIO;
	logic [RATIO_W-1:0] hot_off_ratio  = RST_TEMP_OFF_RATIO;
	logic [RATIO_W-1:0] touch_lo_ratio = RST_TOUCH_LOW_RATIO;
	logic [RATIO_W-1:0] touch_hi_ratio = RST_TOUCH_HIGH_RATIO;

	// Shadow copy of the averaging and indicator state, all cleared by reset.
	logic [12:0]      light_acc     = '0;
	logic [12:0]      touch_acc     = '0;
	logic [12:0]      temp_acc      = '0;
	int               sets_in_window = 0;
	bit               have_base     = 1'b0;
	logic [ADC_W-1:0] base_light    = '0;
	logic [ADC_W-1:0] base_touch    = '0;
	logic [ADC_W-1:0] base_temp     = '0;
	bit               dark_lit      = 1'b0;
	bit               hot_lit       = 1'b0;
	bit               reversed      = 1'b0;
	bit               touching_prev = 1'b0;

	// Sample sets waiting to be sent, and control outputs that the block still owes.
	in_item_t  pending_sets[$];
	out_item_t due_controls[$];

	int unsigned sets_queued   = 0;
	int unsigned sets_accepted = 0;
	int unsigned mismatches    = 0;
	int unsigned send_gap      = 0;
	int unsigned send_calm     = 0;
	int unsigned hold_left     = 0;
	int unsigned hold_calm     = 0;
	int unsigned idle_cycles   = 0;

	// Adds one accepted sample set to the running sums. When it closes a window, the
	// truncated averages either become the baseline (first window only, no output) or
	// drive the comparators, and the resulting control outputs are queued as due.
	task automatic average_and_compare(input in_item_t s);
		logic [ADC_W-1:0] l_avg;
		logic [ADC_W-1:0] t_avg;
		logic [ADC_W-1:0] p_avg;
		logic [31:0]      l_scaled;
		logic [31:0]      t_scaled;
		logic [31:0]      p_scaled;
		bit               in_window;
		int               span_eff;
		int               pct;
		out_item_t        ctl;
		light_acc += s.light_sample;
		touch_acc += s.touch_sample;
		temp_acc  += s.temp_sample;
		sets_in_window++;
		if (sets_in_window < AVG_COUNT)
			return;
		l_avg = ADC_W'(light_acc / AVG_COUNT);
		t_avg = ADC_W'(touch_acc / AVG_COUNT);
		p_avg = ADC_W'(temp_acc / AVG_COUNT);
		light_acc = '0;
		touch_acc = '0;
		temp_acc  = '0;
		sets_in_window = 0;
		if (!have_base) begin
			base_light = l_avg;
			base_touch = t_avg;
			base_temp  = p_avg;
			have_base  = 1'b1;
			return;
		end
		// Thresholds are base * ratio / 1024, compared exactly by scaling the average.
		l_scaled = 32'(l_avg) << 10;
		t_scaled = 32'(t_avg) << 10;
		p_scaled = 32'(p_avg) << 10;
		// When both dark tests hold, the later one (off) wins.
		if (l_scaled >= 32'(base_light) * 32'(dark_on_ratio))
			dark_lit = 1'b1;
		if (l_scaled <= 32'(base_light) * 32'(dark_off_ratio))
			dark_lit = 1'b0;
		// The on test has priority; between the two thresholds the LED keeps its state.
		if (p_scaled > 32'(base_temp) * 32'(hot_on_ratio))
			hot_lit = 1'b1;
		else if (p_scaled < 32'(base_temp) * 32'(hot_off_ratio))
			hot_lit = 1'b0;
		// Direction flips only on entry into the touch window.
		in_window = (t_scaled < 32'(base_touch) * 32'(touch_hi_ratio)) &&
			(t_scaled > 32'(base_touch) * 32'(touch_lo_ratio));
		if (in_window && !touching_prev)
			reversed = !reversed;
		touching_prev = in_window;
		// Signed percent with truncation toward zero; a zero span counts as one.
		span_eff = (span == '0) ? 1 : int'(span);
		pct = ((int'(l_avg) - int'(zero_point)) * PCT_SCALE) / span_eff;
		if (pct <= ZERO_PCT_LIMIT)
			pct = 0;
		else if (pct >= FULL_PCT_LIMIT)
			pct = PCT_FULL_VALUE;
		ctl.dim_percent   = PCT_W'(pct);
		ctl.dark_led      = dark_lit;
		ctl.temp_led      = hot_lit;
		ctl.motor_reverse = reversed;
		due_controls.push_back(ctl);
	endtask

	// Idle length between beats: mostly none, often short, now and then a long one.
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic void check_field(input string field, input logic [PCT_W-1:0] want,
		input logic [PCT_W-1:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
			mismatches++;
		end
	endfunction

	// Sample driver. The predictor runs on each accepted beat, so the shadow
	// registers always match those the block uses for that beat's window.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample       <= '0;
		end else begin
			if (sample_valid && !sample_stall) begin
				average_and_compare(sample);
				sets_accepted++;
				// A calm stretch sends back to back; otherwise draw a random gap.
				if (send_calm > 0) begin
					send_calm--;
					send_gap = 0;
				end else begin
					if ($urandom_range(0, 24) == 0)
						send_calm = $urandom_range(20, 60);
					send_gap = gap_len();
				end
			end
			// A beat that is still stalled stays on the bus unchanged.
			if (!sample_valid || !sample_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					sample_valid <= 1'b0;
				end else if (pending_sets.size() != 0) begin
					sample       <= pending_sets.pop_front();
					sample_valid <= 1'b1;
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and stall generator. Each accepted result beat is matched
	// against the oldest due control set, field by field.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (due_controls.size() == 0) begin
					$display("%0t ns: unexpected result, expected none actual %p", $time,
						result);
					mismatches++;
				end else begin
					out_item_t want;
					want = due_controls.pop_front();
					check_field("dim_percent", want.dim_percent, result.dim_percent);
					check_field("dark_led", PCT_W'(want.dark_led), PCT_W'(result.dark_led));
					check_field("temp_led", PCT_W'(want.temp_led), PCT_W'(result.temp_led));
					check_field("motor_reverse", PCT_W'(want.motor_reverse),
						PCT_W'(result.motor_reverse));
				end
			end
			// Stall runs are never back to back: result_stall drops between any two of them.
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
				if (hold_calm > 0) begin
					hold_calm--;
				end else begin
					if ($urandom_range(0, 24) == 0)
						hold_calm = $urandom_range(20, 60);
					hold_left = gap_len();
				end
			end
		end
	end

	// Hang detector: any accepted beat on any channel restarts the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("%0t ns: no beat accepted for %0d cycles", $time, HANG_LIMIT);
				$display("** sensor_average_hysteresis_controller: FAILED **");
				$finish;
			end
		end
	end

	function automatic logic [ADC_W-1:0] clamp_adc(input int v);
		if (v < 0)
			return '0;
		if (v > 1023)
			return 10'd1023;
		return ADC_W'(v);
	endfunction

	// Average level at which base * ratio / 1024 lies, jittered by a couple of counts.
	function automatic logic [ADC_W-1:0] near_threshold(input logic [ADC_W-1:0] base,
		input logic [RATIO_W-1:0] ratio);
		return clamp_adc(int'((32'(base) * 32'(ratio)) >> 10) +
			int'($urandom_range(0, 4)) - 2);
	endfunction

	function automatic logic [ADC_W-1:0] rail();
		return $urandom_range(0, 1) ? 10'd1023 : 10'd0;
	endfunction

	task automatic queue_set(input logic [ADC_W-1:0] l, input logic [ADC_W-1:0] t,
		input logic [ADC_W-1:0] p);
		in_item_t s;
		s.light_sample = l;
		s.touch_sample = t;
		s.temp_sample  = p;
		pending_sets.push_back(s);
		sets_queued++;
	endtask

	// Queues one window of five sets whose samples scatter around the given averages.
	// The last set makes up the difference, so the average hits the target unless a
	// sample had to be clamped at a rail.
	task automatic queue_window(input int l, input int t, input int p);
		int sum_l;
		int sum_t;
		int sum_p;
		logic [ADC_W-1:0] sl;
		logic [ADC_W-1:0] st;
		logic [ADC_W-1:0] sp;
		sum_l = 0;
		sum_t = 0;
		sum_p = 0;
		for (int k = 0; k < AVG_COUNT; k++) begin
			if (k < AVG_COUNT - 1) begin
				sl = clamp_adc(l + int'($urandom_range(0, 12)) - 6);
				st = clamp_adc(t + int'($urandom_range(0, 12)) - 6);
				sp = clamp_adc(p + int'($urandom_range(0, 12)) - 6);
			end else begin
				sl = clamp_adc(AVG_COUNT * l - sum_l);
				st = clamp_adc(AVG_COUNT * t - sum_t);
				sp = clamp_adc(AVG_COUNT * p - sum_p);
			end
			sum_l += int'(sl);
			sum_t += int'(st);
			sum_p += int'(sp);
			queue_set(sl, st, sp);
		end
	endtask

	// Random windows aimed at the comparator thresholds and the percent limits of the
	// current register setting, mixed with uniform levels, rails and pure noise.
	task automatic queue_random_windows(input int count);
		int l;
		int t;
		int p;
		int span_eff;
		for (int w = 0; w < count; w++) begin
			if ($urandom_range(0, 9) == 0) begin
				for (int k = 0; k < AVG_COUNT; k++)
					queue_set(ADC_W'($urandom_range(0, 1023)),
						ADC_W'($urandom_range(0, 1023)),
						ADC_W'($urandom_range(0, 1023)));
			end else begin
				span_eff = (span == '0) ? 1 : int'(span);
				case ($urandom_range(0, 5))
					0: l = int'(near_threshold(base_light, dark_on_ratio));
					1: l = int'(near_threshold(base_light, dark_off_ratio));
					2: l = int'(clamp_adc(int'(zero_point) +
						span_eff * ZERO_PCT_LIMIT / PCT_SCALE +
						int'($urandom_range(0, 4)) - 2));
					3: l = int'(clamp_adc(int'(zero_point) +
						span_eff * FULL_PCT_LIMIT / PCT_SCALE +
						int'($urandom_range(0, 4)) - 2));
					4: l = int'($urandom_range(0, 1023));
					default: l = int'(rail());
				endcase
				case ($urandom_range(0, 4))
					0: t = int'(near_threshold(base_touch, touch_lo_ratio));
					1: t = int'(near_threshold(base_touch, touch_hi_ratio));
					2: t = (int'(near_threshold(base_touch, touch_lo_ratio)) +
						int'(near_threshold(base_touch, touch_hi_ratio))) / 2;
					3: t = int'($urandom_range(0, 1023));
					default: t = int'(rail());
				endcase
				case ($urandom_range(0, 3))
					0: p = int'(near_threshold(base_temp, hot_on_ratio));
					1: p = int'(near_threshold(base_temp, hot_off_ratio));
					2: p = int'($urandom_range(0, 1023));
					default: p = int'(rail());
				endcase
				queue_window(l, t, p);
			end
		end
	endtask

	// One register write. Each write starts on a fresh edge, so cfg_valid sees a
	// single assignment per time step.
	task automatic cfg_write(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		// The 10-bit registers keep only the low bits of the data.
		case (idx)
			CFG_LIGHT_ZERO_POINT: zero_point     = data[ADC_W-1:0];
			CFG_LIGHT_SPAN:       span           = data[ADC_W-1:0];
			CFG_LIGHT_ON_RATIO:   dark_on_ratio  = data;
			CFG_LIGHT_OFF_RATIO:  dark_off_ratio = data;
			CFG_TEMP_ON_RATIO:    hot_on_ratio   = data;
			CFG_TEMP_OFF_RATIO:   hot_off_ratio  = data;
			CFG_TOUCH_LOW_RATIO:  touch_lo_ratio = data;
			CFG_TOUCH_HIGH_RATIO: touch_hi_ratio = data;
			default: ;
		endcase
	endtask

	// Loads all eight registers with one setting, in index order.
	task automatic program_registers(input int setting);
		logic [CFG_DATA_W-1:0] vals[8];
		case (setting)
			// Bottom rails: zero span (treated as one), all ratios zero.
			1: vals = '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0};
			// Top rails, with the upper data bits set on the 10-bit registers.
			2: vals = '{12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF};
			// Off thresholds above on thresholds, and an empty touch window.
			3: vals = '{12'd650, 12'd250, 12'd900, 12'd1300, 12'd1000, 12'd1100,
				12'd900, 12'd500};
			// Percent equals the light average, so the limits at 20 and 80 sit on counts.
			4: vals = '{12'd0, 12'd100, 12'd1100, 12'd900, 12'd1100, 12'd900,
				12'd200, 12'd3000};
			default: begin
				foreach (vals[i])
					vals[i] = CFG_DATA_W'($urandom_range(0, 4095));
			end
		endcase
		for (int i = 0; i < 8; i++)
			cfg_write(cfg_index_t'(i), vals[i]);
	endtask

	// Holds the sender until every queued set is accepted and every due result has
	// come back, then lets any result-free window finish inside the block.
	task automatic wait_idle();
		while (sets_accepted != sets_queued || due_controls.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, under the reset register values. The baseline window mixes
		// both rails and averages to 512 on every channel.
		queue_set(10'd1023, 10'd1023, 10'd0);
		queue_set(10'd0, 10'd0, 10'd1023);
		queue_set(10'd512, 10'd512, 10'd600);
		queue_set(10'd511, 10'd511, 10'd400);
		queue_set(10'd514, 10'd514, 10'd537);
		// Everything at full scale: percent saturates, both LEDs on, touch outside.
		queue_window(1023, 1023, 1023);
		// Touch enters its window and flips the motor; temperature in its dead zone.
		queue_window(900, 350, 530);
		// Light in the dark dead zone; touch stays inside, so no second flip.
		queue_window(600, 360, 530);
		// Everything at zero: both LEDs off, touch leaves the window.
		queue_window(0, 0, 0);
		queue_random_windows(15);
		wait_idle();

		// Register settings: the rails and special orderings first, then random ones.
		// Some phases end mid-window, so a window can straddle a register change.
		for (int setting = 1; setting < 10; setting++) begin
			program_registers(setting);
			queue_random_windows(19);
			repeat ($urandom_range(0, 3))
				queue_set(ADC_W'($urandom_range(0, 1023)), ADC_W'($urandom_range(0, 1023)),
					ADC_W'($urandom_range(0, 1023)));
			wait_idle();
		end

		if (due_controls.size() != 0) begin
			$display("%0t ns: %0d results expected but never delivered", $time,
				due_controls.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("** sensor_average_hysteresis_controller: PASSED **");
		else
			$display("** sensor_average_hysteresis_controller: FAILED **");
		$finish;
	end

endmodule
